>>> hw/rtl/fo_pkg.sv
// Shared constants and beat types for the frame orthonormalizer.
`default_nettype none
package fo_pkg;
   localparam int OUT_BITS  = 16;
   localparam int FRAC_BITS = 14;
   localparam int UNIT_ONE  = 16384;
   localparam int SHIFT_LEN = 30;
   localparam int SQ_BITS   = 2 * SHIFT_LEN + 2;
   localparam int ROOT_BITS = SQ_BITS / 2;
   localparam int REM_BITS  = ROOT_BITS + 3;
   localparam int NUM_BITS  = SHIFT_LEN + FRAC_BITS + 1;
   localparam int QUO_BITS  = FRAC_BITS + 1;
   localparam int DREM_BITS = ROOT_BITS;
   localparam int NORM_LAT  = 6 + ROOT_BITS + 1 + QUO_BITS + 1;
   localparam int CROSS_LAT = 5;

   typedef enum logic [2:0] {
      PLANE_XY, PLANE_YX, PLANE_YZ, PLANE_ZY, PLANE_ZX, PLANE_XZ, PLANE_PASS_A, PLANE_PASS_B
   } plane_type;

   typedef struct packed {
      logic [SQ_BITS-1:0]   rad;
      logic [ROOT_BITS-1:0] root;
      logic [REM_BITS-1:0]  rem;
   } sqrt_beat_type;

   typedef struct packed {
      logic [2:0][DREM_BITS-1:0] rem;
      logic [2:0][QUO_BITS-1:0]  bits;
      logic [2:0][QUO_BITS-1:0]  quo;
      logic [ROOT_BITS-1:0]      divisor;
   } div_beat_type;
endpackage
`default_nettype wire

>>> hw/rtl/fo_sqrt_cell.sv
// One digit cell of the pipelined integer square root.
`default_nettype none
module fo_sqrt_cell (
   input  logic                  clock,
   input  logic                  advance,
   input  fo_pkg::sqrt_beat_type from_prev,
   output fo_pkg::sqrt_beat_type to_next
);
   import fo_pkg::*;

   logic [REM_BITS-1:0] rem_cat;
   logic [REM_BITS-1:0] trial;
   logic                take;
   sqrt_beat_type       beat_in;
   sqrt_beat_type       beat_ff;

   always_comb begin
      rem_cat = {from_prev.rem[REM_BITS-3:0], from_prev.rad[SQ_BITS-1 -: 2]};
      trial   = REM_BITS'({from_prev.root, 2'b01});
      take    = (rem_cat >= trial);
      beat_in.rad  = from_prev.rad << 2;
      beat_in.root = {from_prev.root[ROOT_BITS-2:0], take};
      beat_in.rem  = take ? (rem_cat - trial) : rem_cat;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         beat_ff <= beat_in;
      end
   end

   assign to_next = beat_ff;
endmodule
`default_nettype wire

>>> hw/rtl/fo_div_cell.sv
// One quotient-bit cell of the three-lane restoring divider.
`default_nettype none
module fo_div_cell (
   input  logic                 clock,
   input  logic                 advance,
   input  fo_pkg::div_beat_type from_prev,
   output fo_pkg::div_beat_type to_next
);
   import fo_pkg::*;

   logic [DREM_BITS:0] cat   [3];
   logic [DREM_BITS:0] diff  [3];
   logic [2:0]         take;
   div_beat_type       beat_in;
   div_beat_type       beat_ff;

   always_comb begin
      beat_in.divisor = from_prev.divisor;
      for (int l = 0; l < 3; l++) begin
         cat[l]  = {from_prev.rem[l], from_prev.bits[l][QUO_BITS-1]};
         diff[l] = cat[l] - {1'b0, from_prev.divisor};
         take[l] = (cat[l] >= {1'b0, from_prev.divisor});
         beat_in.rem[l]  = take[l] ? diff[l][DREM_BITS-1:0] : cat[l][DREM_BITS-1:0];
         beat_in.bits[l] = from_prev.bits[l] << 1;
         beat_in.quo[l]  = {from_prev.quo[l][QUO_BITS-2:0], take[l]};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         beat_ff <= beat_in;
      end
   end

   assign to_next = beat_ff;
endmodule
`default_nettype wire

>>> hw/rtl/fo_norm.sv
// Vector normalizer: scale to 30 bits, square root chain, divider chain, Q1.14 out.
`default_nettype none
module fo_norm #(
   parameter int VEC_BITS = 50
) (
   input  logic                                clock,
   input  logic                                advance,
   input  logic signed [VEC_BITS-1:0]          vec_x,
   input  logic signed [VEC_BITS-1:0]          vec_y,
   input  logic signed [VEC_BITS-1:0]          vec_z,
   output logic signed [fo_pkg::OUT_BITS-1:0] unit_x,
   output logic signed [fo_pkg::OUT_BITS-1:0] unit_y,
   output logic signed [fo_pkg::OUT_BITS-1:0] unit_z
);
   import fo_pkg::*;

   localparam int CHUNKS    = (VEC_BITS + 7) / 8;
   localparam int CIDX_BITS = $clog2(CHUNKS);
   localparam int LEN_BITS  = $clog2(VEC_BITS + 1);

   typedef struct packed {
      logic [2:0][SHIFT_LEN-1:0] s;
      logic [2:0]                neg;
      logic                      nz;
   } side_type;

   logic signed [VEC_BITS-1:0] vec [3];
   logic [2:0][VEC_BITS-1:0]   mag_in, mag_ff, mag2_ff, mag3_ff;
   logic [2:0]                 neg_in, neg_ff, neg2_ff, neg3_ff;
   logic [CHUNKS*8-1:0]        all_pad;
   logic [CIDX_BITS-1:0]       top_in, top_ff;
   logic [7:0]                 byte_in, byte_ff;
   logic [3:0]                 blen;
   logic [LEN_BITS-1:0]        len_in, len_ff;
   logic [VEC_BITS+SHIFT_LEN-1:0] ext_v [3];
   side_type                   sh_in, sh_ff, sq_side_ff, sum_side_ff;
   logic [2:0][2*SHIFT_LEN-1:0] sq_in, sq_ff;
   logic [SQ_BITS-1:0]         sum_in, sum_ff;
   sqrt_beat_type              sq_chain [ROOT_BITS+1];
   side_type                   sq_dly_ff [ROOT_BITS];
   div_beat_type               div_chain [QUO_BITS+1];
   div_beat_type               div0_in;
   div_beat_type               div0_ff;
   side_type                   div_dly_ff [QUO_BITS+1];
   logic [NUM_BITS-1:0]        num [3];
   logic signed [OUT_BITS-1:0] unit_in [3];
   logic signed [OUT_BITS-1:0] unit_ff [3];
   side_type                   last_side;

   assign vec[0] = vec_x;
   assign vec[1] = vec_y;
   assign vec[2] = vec_z;

   // Magnitudes, then the leading byte, then the exact bit length.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         neg_in[i] = vec[i][VEC_BITS-1];
         mag_in[i] = neg_in[i] ? VEC_BITS'(-vec[i]) : VEC_BITS'(vec[i]);
      end
      all_pad = (CHUNKS*8)'(mag_ff[0] | mag_ff[1] | mag_ff[2]);
      top_in  = '0;
      for (int c = 0; c < CHUNKS; c++) begin
         if (|all_pad[c*8 +: 8]) top_in = CIDX_BITS'(c);
      end
      byte_in = all_pad[{top_in, 3'b000} +: 8];
      blen = '0;
      for (int b = 0; b < 8; b++) begin
         if (byte_ff[b]) blen = 4'(b + 1);
      end
      len_in = LEN_BITS'({top_ff, 3'b000}) + LEN_BITS'(blen);
   end

   // Placing the magnitude above 30 zero bits and shifting right by the length
   // covers both the left and the truncating right shift.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ext_v[i]   = {mag3_ff[i], {SHIFT_LEN{1'b0}}} >> len_ff;
         sh_in.s[i] = ext_v[i][SHIFT_LEN-1:0];
         sq_in[i]   = (2*SHIFT_LEN)'(sh_ff.s[i]) * (2*SHIFT_LEN)'(sh_ff.s[i]);
      end
      sh_in.neg = neg3_ff;
      sh_in.nz  = (len_ff != '0);
      sum_in = SQ_BITS'(sq_ff[0]) + SQ_BITS'(sq_ff[1]) + SQ_BITS'(sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mag_ff      <= mag_in;
         neg_ff      <= neg_in;
         mag2_ff     <= mag_ff;
         neg2_ff     <= neg_ff;
         top_ff      <= top_in;
         byte_ff     <= byte_in;
         mag3_ff     <= mag2_ff;
         neg3_ff     <= neg2_ff;
         len_ff      <= len_in;
         sh_ff       <= sh_in;
         sq_ff       <= sq_in;
         sq_side_ff  <= sh_ff;
         sum_ff      <= sum_in;
         sum_side_ff <= sq_side_ff;
      end
   end

   assign sq_chain[0] = '{rad: sum_ff, root: '0, rem: '0};

   for (genvar j = 0; j < ROOT_BITS; j++) begin : g_sqrt
      fo_sqrt_cell u_cell (
         .clock     (clock),
         .advance   (advance),
         .from_prev (sq_chain[j]),
         .to_next   (sq_chain[j+1])
      );
   end

   // Rounded dividend and the first partial remainder for each lane.
   always_comb begin
      div0_in.divisor = sq_chain[ROOT_BITS].root;
      for (int l = 0; l < 3; l++) begin
         num[l] = NUM_BITS'({sq_dly_ff[ROOT_BITS-1].s[l], {FRAC_BITS{1'b0}}})
                + NUM_BITS'(sq_chain[ROOT_BITS].root >> 1);
         div0_in.rem[l]  = DREM_BITS'(num[l][NUM_BITS-1:QUO_BITS]);
         div0_in.bits[l] = num[l][QUO_BITS-1:0];
         div0_in.quo[l]  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_dly_ff[0] <= sum_side_ff;
         for (int j = 1; j < ROOT_BITS; j++) sq_dly_ff[j] <= sq_dly_ff[j-1];
         div0_ff       <= div0_in;
         div_dly_ff[0] <= sq_dly_ff[ROOT_BITS-1];
         for (int j = 1; j <= QUO_BITS; j++) div_dly_ff[j] <= div_dly_ff[j-1];
      end
   end

   assign div_chain[0] = div0_ff;

   for (genvar j = 0; j < QUO_BITS; j++) begin : g_div
      fo_div_cell u_cell (
         .clock     (clock),
         .advance   (advance),
         .from_prev (div_chain[j]),
         .to_next   (div_chain[j+1])
      );
   end

   assign last_side = div_dly_ff[QUO_BITS];

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         if (!last_side.nz) begin
            unit_in[l] = '0;
         end else if (last_side.neg[l]) begin
            unit_in[l] = -OUT_BITS'(div_chain[QUO_BITS].quo[l]);
         end else begin
            unit_in[l] = OUT_BITS'(div_chain[QUO_BITS].quo[l]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int l = 0; l < 3; l++) unit_ff[l] <= unit_in[l];
      end
   end

   assign unit_x = unit_ff[0];
   assign unit_y = unit_ff[1];
   assign unit_z = unit_ff[2];
endmodule
`default_nettype wire

>>> hw/rtl/frame_orthonormalizer.sv
// Top level: two cross products chosen by datum plane, then three normalizer chains.
// Pipeline: 5 cross-product stages, then 54 normalizer stages (31 square-root cells
// and 15 divider cells among them).
// Throughput: one beat per cycle; a stalled result freezes the whole pipeline.
// Reset clears only the valid pipeline; no result is presented after reset.
`default_nettype none
module frame_orthonormalizer #(
   parameter int COMPONENT_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [COMPONENT_BITS-1:0]    req_xaxis_in_x,
   input  logic signed [COMPONENT_BITS-1:0]    req_xaxis_in_y,
   input  logic signed [COMPONENT_BITS-1:0]    req_xaxis_in_z,
   input  logic signed [COMPONENT_BITS-1:0]    req_yaxis_in_x,
   input  logic signed [COMPONENT_BITS-1:0]    req_yaxis_in_y,
   input  logic signed [COMPONENT_BITS-1:0]    req_yaxis_in_z,
   input  logic signed [COMPONENT_BITS-1:0]    req_zaxis_in_x,
   input  logic signed [COMPONENT_BITS-1:0]    req_zaxis_in_y,
   input  logic signed [COMPONENT_BITS-1:0]    req_zaxis_in_z,
   input  logic [2:0]                          req_datum_plane,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [fo_pkg::OUT_BITS-1:0] rsp_xaxis_out_x,
   output logic signed [fo_pkg::OUT_BITS-1:0] rsp_xaxis_out_y,
   output logic signed [fo_pkg::OUT_BITS-1:0] rsp_xaxis_out_z,
   output logic signed [fo_pkg::OUT_BITS-1:0] rsp_yaxis_out_x,
   output logic signed [fo_pkg::OUT_BITS-1:0] rsp_yaxis_out_y,
   output logic signed [fo_pkg::OUT_BITS-1:0] rsp_yaxis_out_z,
   output logic signed [fo_pkg::OUT_BITS-1:0] rsp_zaxis_out_x,
   output logic signed [fo_pkg::OUT_BITS-1:0] rsp_zaxis_out_y,
   output logic signed [fo_pkg::OUT_BITS-1:0] rsp_zaxis_out_z,
   output logic                                rsp_frame_valid
);
   import fo_pkg::*;

   localparam int CB        = COMPONENT_BITS;
   localparam int PW        = 2 * CB;
   localparam int W1        = 2 * CB + 1;
   localparam int VW        = 3 * CB + 2;
   localparam int HW        = CB + 1;
   localparam int TOTAL_LAT = CROSS_LAT + NORM_LAT;

   typedef logic [1:0] axis_type;
   localparam axis_type AXIS_X = 2'd0;
   localparam axis_type AXIS_Y = 2'd1;
   localparam axis_type AXIS_Z = 2'd2;

   typedef struct packed {
      axis_type t1;
      axis_type t2;
      axis_type k;
      logic     w_first;
   } route_type;

   typedef struct packed {
      logic                       pass;
      logic [8:0][OUT_BITS-1:0]   raw;
      logic                       raw_ok;
   } side_type;

   function automatic axis_type next_axis(axis_type a);
      return (a == AXIS_Z) ? AXIS_X : axis_type'(a + 2'd1);
   endfunction

   // t1 is rebuilt from the two original axes, t2 from t1 and the kept axis k.
   function automatic route_type decode_plane(plane_type p);
      route_type r;
      unique case (p) inside
         PLANE_XY: begin r.t1 = AXIS_Z; r.t2 = AXIS_Y; end
         PLANE_YX: begin r.t1 = AXIS_Z; r.t2 = AXIS_X; end
         PLANE_YZ: begin r.t1 = AXIS_X; r.t2 = AXIS_Z; end
         PLANE_ZY: begin r.t1 = AXIS_X; r.t2 = AXIS_Y; end
         PLANE_ZX: begin r.t1 = AXIS_Y; r.t2 = AXIS_X; end
         PLANE_XZ: begin r.t1 = AXIS_Y; r.t2 = AXIS_Z; end
         PLANE_PASS_A, PLANE_PASS_B: begin r.t1 = AXIS_Z; r.t2 = AXIS_Y; end
      endcase
      r.k       = axis_type'(2'd3 - r.t1 - r.t2);
      r.w_first = (next_axis(r.t2) == r.t1);
      return r;
   endfunction

   logic                     advance;
   logic signed [CB-1:0]     ax [3][3];
   plane_type                plane_v;
   route_type                rt_in, rt1_ff, rt2_ff, rt3_ff, rt4_ff;
   axis_type                 pa, qa;
   logic signed [PW-1:0]     p1_in [6];
   logic signed [PW-1:0]     p1_ff [6];
   logic signed [CB-1:0]     k_in [3];
   logic signed [CB-1:0]     k1_ff [3], k2_ff [3], k3_ff [3], k4_ff [3];
   logic signed [W1-1:0]     w2_ff [3], w3_ff [3], w4_ff [3];
   logic signed [HW-1:0]     wh [3];
   logic signed [HW-1:0]     wl [3];
   logic signed [W1-1:0]     hp3_in [6], lp3_in [6];
   logic signed [W1-1:0]     hp3_ff [6], lp3_ff [6];
   logic signed [W1:0]       hd4_in [3], ld4_in [3];
   logic signed [W1:0]       hd4_ff [3], ld4_ff [3];
   logic signed [VW-1:0]     c2 [3];
   logic signed [VW-1:0]     vec5_in [3][3];
   logic signed [VW-1:0]     vec5_ff [3][3];
   logic signed [OUT_BITS-1:0] unit [3][3];
   side_type                 side_in;
   side_type                 side_ff [TOTAL_LAT];
   logic [TOTAL_LAT-1:0]     vld_ff;
   side_type                 side_out;

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   assign ax[0][0] = req_xaxis_in_x;
   assign ax[0][1] = req_xaxis_in_y;
   assign ax[0][2] = req_xaxis_in_z;
   assign ax[1][0] = req_yaxis_in_x;
   assign ax[1][1] = req_yaxis_in_y;
   assign ax[1][2] = req_yaxis_in_z;
   assign ax[2][0] = req_zaxis_in_x;
   assign ax[2][1] = req_zaxis_in_y;
   assign ax[2][2] = req_zaxis_in_z;
   assign plane_v  = plane_type'(req_datum_plane);

   // First cross product: operand products straight from the input beat.
   always_comb begin
      rt_in = decode_plane(plane_v);
      pa    = next_axis(rt_in.t1);
      qa    = next_axis(pa);
      p1_in[0] = ax[pa][1] * ax[qa][2];
      p1_in[1] = ax[pa][2] * ax[qa][1];
      p1_in[2] = ax[pa][2] * ax[qa][0];
      p1_in[3] = ax[pa][0] * ax[qa][2];
      p1_in[4] = ax[pa][0] * ax[qa][1];
      p1_in[5] = ax[pa][1] * ax[qa][0];
      for (int c = 0; c < 3; c++) k_in[c] = ax[rt_in.k][c];
   end

   always_comb begin
      side_in.pass = (plane_v == PLANE_PASS_A) || (plane_v == PLANE_PASS_B);
      for (int a = 0; a < 3; a++) begin
         for (int c = 0; c < 3; c++) side_in.raw[3*a+c] = OUT_BITS'(ax[a][c]);
      end
      side_in.raw_ok = ((ax[0][0] != '0) || (ax[0][1] != '0) || (ax[0][2] != '0))
                    && ((ax[1][0] != '0) || (ax[1][1] != '0) || (ax[1][2] != '0))
                    && ((ax[2][0] != '0) || (ax[2][1] != '0) || (ax[2][2] != '0));
   end

   // Second cross product W x K: W is split into a signed high half and an
   // unsigned low half so each multiplier stays near CB by CB.
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         wh[j] = w2_ff[j][W1-1:CB];
         wl[j] = {1'b0, w2_ff[j][CB-1:0]};
      end
      for (int c = 0; c < 3; c++) begin
         hp3_in[2*c]   = wh[(c+1)%3] * k2_ff[(c+2)%3];
         hp3_in[2*c+1] = wh[(c+2)%3] * k2_ff[(c+1)%3];
         lp3_in[2*c]   = wl[(c+1)%3] * k2_ff[(c+2)%3];
         lp3_in[2*c+1] = wl[(c+2)%3] * k2_ff[(c+1)%3];
      end
      // K x W is the negative of W x K, so the subtraction order flips.
      for (int c = 0; c < 3; c++) begin
         if (rt3_ff.w_first) begin
            hd4_in[c] = (W1+1)'(hp3_ff[2*c]) - (W1+1)'(hp3_ff[2*c+1]);
            ld4_in[c] = (W1+1)'(lp3_ff[2*c]) - (W1+1)'(lp3_ff[2*c+1]);
         end else begin
            hd4_in[c] = (W1+1)'(hp3_ff[2*c+1]) - (W1+1)'(hp3_ff[2*c]);
            ld4_in[c] = (W1+1)'(lp3_ff[2*c+1]) - (W1+1)'(lp3_ff[2*c]);
         end
         c2[c] = (VW'(hd4_ff[c]) <<< CB) + VW'(ld4_ff[c]);
      end
      for (int a = 0; a < 3; a++) begin
         for (int c = 0; c < 3; c++) begin
            if (axis_type'(a) == rt4_ff.k) begin
               vec5_in[a][c] = VW'(k4_ff[c]);
            end else if (axis_type'(a) == rt4_ff.t1) begin
               vec5_in[a][c] = VW'(w4_ff[c]);
            end else begin
               vec5_in[a][c] = c2[c];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 6; i++) begin
            p1_ff[i]  <= p1_in[i];
            hp3_ff[i] <= hp3_in[i];
            lp3_ff[i] <= lp3_in[i];
         end
         for (int c = 0; c < 3; c++) begin
            k1_ff[c]  <= k_in[c];
            k2_ff[c]  <= k1_ff[c];
            k3_ff[c]  <= k2_ff[c];
            k4_ff[c]  <= k3_ff[c];
            w2_ff[c]  <= W1'(p1_ff[2*c]) - W1'(p1_ff[2*c+1]);
            w3_ff[c]  <= w2_ff[c];
            w4_ff[c]  <= w3_ff[c];
            hd4_ff[c] <= hd4_in[c];
            ld4_ff[c] <= ld4_in[c];
            for (int a = 0; a < 3; a++) vec5_ff[a][c] <= vec5_in[a][c];
         end
         rt1_ff <= rt_in;
         rt2_ff <= rt1_ff;
         rt3_ff <= rt2_ff;
         rt4_ff <= rt3_ff;
         side_ff[0] <= side_in;
         for (int i = 1; i < TOTAL_LAT; i++) side_ff[i] <= side_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[TOTAL_LAT-2:0], req_valid};
      end
   end

   for (genvar a = 0; a < 3; a++) begin : g_axis
      fo_norm #(
         .VEC_BITS (VW)
      ) u_norm (
         .clock   (clock),
         .advance (advance),
         .vec_x   (vec5_ff[a][0]),
         .vec_y   (vec5_ff[a][1]),
         .vec_z   (vec5_ff[a][2]),
         .unit_x  (unit[a][0]),
         .unit_y  (unit[a][1]),
         .unit_z  (unit[a][2])
      );
   end

   assign side_out  = side_ff[TOTAL_LAT-1];
   assign rsp_valid = vld_ff[TOTAL_LAT-1];

   assign rsp_xaxis_out_x = side_out.pass ? side_out.raw[0] : unit[0][0];
   assign rsp_xaxis_out_y = side_out.pass ? side_out.raw[1] : unit[0][1];
   assign rsp_xaxis_out_z = side_out.pass ? side_out.raw[2] : unit[0][2];
   assign rsp_yaxis_out_x = side_out.pass ? side_out.raw[3] : unit[1][0];
   assign rsp_yaxis_out_y = side_out.pass ? side_out.raw[4] : unit[1][1];
   assign rsp_yaxis_out_z = side_out.pass ? side_out.raw[5] : unit[1][2];
   assign rsp_zaxis_out_x = side_out.pass ? side_out.raw[6] : unit[2][0];
   assign rsp_zaxis_out_y = side_out.pass ? side_out.raw[7] : unit[2][1];
   assign rsp_zaxis_out_z = side_out.pass ? side_out.raw[8] : unit[2][2];

   assign rsp_frame_valid = side_out.pass ? side_out.raw_ok :
      ((unit[0][0] != '0) || (unit[0][1] != '0) || (unit[0][2] != '0))
      && ((unit[1][0] != '0) || (unit[1][1] != '0) || (unit[1][2] != '0))
      && ((unit[2][0] != '0) || (unit[2][1] != '0) || (unit[2][2] != '0));

   a_stall_only_when_blocked: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while the result side can move");

   a_no_result_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat presented right after reset");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !side_out.pass) |->
         (rsp_xaxis_out_x <= UNIT_ONE) && (rsp_xaxis_out_x >= -UNIT_ONE)
         && (rsp_yaxis_out_y <= UNIT_ONE) && (rsp_yaxis_out_y >= -UNIT_ONE)
         && (rsp_zaxis_out_z <= UNIT_ONE) && (rsp_zaxis_out_z >= -UNIT_ONE))
      else $error("normalized component outside the unit range");
endmodule
`default_nettype wire
